>>> design/lru_kv_pkg.sv
// Shared constants and types for the LRU key-value cache.
`default_nettype none
package lru_kv_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int FIELD_W = 32;
  localparam int CNT_W   = 32;
  localparam int CAP_W   = 5;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  localparam int KEY_BITS = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
  localparam int VAL_BITS = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // look up, update state and load the result
  } cmd_t;

endpackage
`default_nettype wire

>>> design/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
`default_nettype none
// Fully associative key-value cache of lru_kv_pkg::ENTRIES entries with
// least-recently-used replacement. Each request is a get (mode 0) or a put
// (mode 1); every request gives exactly one result with the hit flag, the
// value read on a get hit, the eviction flag and the three saturating
// counters. A request is first captured; then, in the update step, all
// entries compare the key in parallel and the recency ranks, entry
// store and counters are updated. A new request is taken the cycle after
// that update, while the previous result may still wait in the output
// register; the update step stalls only if that register is still full.
// Capacity (0 reads as 1, above the entry count as the entry count) may be
// written only while no request is in flight.
module lru_key_value_cache (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [lru_kv_pkg::CAP_W-1:0]        cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 mode,
  input  wire  signed [lru_kv_pkg::FIELD_W-1:0] key,
  input  wire  signed [lru_kv_pkg::FIELD_W-1:0] value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                hit,
  output logic signed [lru_kv_pkg::FIELD_W-1:0] read_value,
  output logic                                evicted,
  output logic [lru_kv_pkg::CNT_W-1:0]        hit_total,
  output logic [lru_kv_pkg::CNT_W-1:0]        miss_total,
  output logic [lru_kv_pkg::CNT_W-1:0]        eviction_total
);

  lru_kv_pkg::cmd_t            cmd;
  logic [lru_kv_pkg::FIELD_W-1:0] read_value_u;

  lru_kv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lru_kv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .key            (key),
    .value          (value),
    .hit            (hit),
    .read_value     (read_value_u),
    .evicted        (evicted),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  assign read_value = read_value_u;

endmodule
`default_nettype wire

>>> design/lru_kv_ctrl.sv
// Request sequencing and output handshake for the LRU key-value cache.
`default_nettype none
module lru_kv_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output lru_kv_pkg::cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_exec_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not presented after execute");

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EXEC) && !in_ready)
    else $error("request captured but no execute pending");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

endmodule
`default_nettype wire

>>> design/lru_kv_dp.sv
// Entry store, recency ranks, counters and result register of the LRU cache.
`default_nettype none
module lru_kv_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  lru_kv_pkg::cmd_t                     cmd,
  input  wire                                  cfg_we,
  input  wire  [lru_kv_pkg::CAP_W-1:0]         cfg_data,
  input  wire                                  mode,
  input  wire  [lru_kv_pkg::FIELD_W-1:0]       key,
  input  wire  [lru_kv_pkg::FIELD_W-1:0]       value,
  output logic                                 hit,
  output logic [lru_kv_pkg::FIELD_W-1:0]       read_value,
  output logic                                 evicted,
  output logic [lru_kv_pkg::CNT_W-1:0]         hit_total,
  output logic [lru_kv_pkg::CNT_W-1:0]         miss_total,
  output logic [lru_kv_pkg::CNT_W-1:0]         eviction_total
);

  localparam int N = lru_kv_pkg::ENTRIES;

  logic [lru_kv_pkg::CAP_W-1:0]    capacity;
  logic                            req_mode;
  logic [lru_kv_pkg::KEY_BITS-1:0] req_key;
  logic [lru_kv_pkg::VAL_BITS-1:0] req_value;

  logic [lru_kv_pkg::KEY_BITS-1:0] entry_keys   [N];
  logic [lru_kv_pkg::VAL_BITS-1:0] entry_values [N];
  logic [N-1:0]                    entry_valid;
  logic [lru_kv_pkg::RANK_W-1:0]   recency_rank [N];
  logic [lru_kv_pkg::OCC_W-1:0]    occupancy;
  logic [lru_kv_pkg::CNT_W-1:0]    hit_counter;
  logic [lru_kv_pkg::CNT_W-1:0]    miss_counter;
  logic [lru_kv_pkg::CNT_W-1:0]    eviction_counter;

  logic [N-1:0]                  match;
  logic [N-1:0]                  lru_match;
  logic                          found;
  logic [lru_kv_pkg::IDX_W-1:0]  found_idx;
  logic [lru_kv_pkg::IDX_W-1:0]  evict_idx;
  logic [lru_kv_pkg::IDX_W-1:0]  free_idx;
  logic [lru_kv_pkg::IDX_W-1:0]  slot;
  logic [lru_kv_pkg::OCC_W-1:0]  eff_cap;
  logic [lru_kv_pkg::OCC_W-1:0]  occ_dec;
  logic [lru_kv_pkg::RANK_W-1:0] lru_rank;
  logic [lru_kv_pkg::RANK_W-1:0] touch_rank;
  logic                          is_put;
  logic                          full;
  logic                          do_evict;
  logic                          do_insert;
  logic                          do_touch;

  // ranks of valid entries are always a permutation of 0..occupancy-1,
  // so the least recent entry is the one holding rank occupancy-1
  assign occ_dec  = occupancy - lru_kv_pkg::OCC_W'(1);
  assign lru_rank = occ_dec[lru_kv_pkg::RANK_W-1:0];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i]     = entry_valid[i] && (entry_keys[i] == req_key);
      lru_match[i] = entry_valid[i] && (recency_rank[i] == lru_rank);
    end
  end

  // lowest index wins in each encoder
  always_comb begin
    found_idx = '0;
    evict_idx = '0;
    free_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = lru_kv_pkg::IDX_W'(i);
      end
      if (lru_match[i]) begin
        evict_idx = lru_kv_pkg::IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lru_kv_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lru_kv_pkg::OCC_W'(1);
    end else if (capacity > N) begin
      eff_cap = lru_kv_pkg::OCC_W'(N);
    end else begin
      eff_cap = lru_kv_pkg::OCC_W'(capacity);
    end
  end

  assign found      = |match;
  assign is_put     = (req_mode == lru_kv_pkg::MODE_PUT);
  assign full       = (occupancy >= eff_cap);
  assign do_evict   = is_put && !found && full;
  assign do_insert  = is_put && !found;
  assign do_touch   = found;
  assign slot       = do_evict ? evict_idx : free_idx;
  assign touch_rank = recency_rank[found_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lru_kv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode  <= mode;
      req_key   <= key[lru_kv_pkg::KEY_BITS-1:0];
      req_value <= value[lru_kv_pkg::VAL_BITS-1:0];
    end
  end

  // entry payload: no reset, only read where valid
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_insert) begin
        entry_keys[slot]   <= req_key;
        entry_values[slot] <= req_value;
      end else if (is_put && found) begin
        entry_values[found_idx] <= req_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < N; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_touch) begin
        for (int i = 0; i < N; i++) begin
          if (lru_kv_pkg::IDX_W'(i) == found_idx) begin
            recency_rank[i] <= '0;
          end else if (entry_valid[i] && (recency_rank[i] < touch_rank)) begin
            recency_rank[i] <= recency_rank[i] + lru_kv_pkg::RANK_W'(1);
          end
        end
      end else if (do_insert) begin
        for (int i = 0; i < N; i++) begin
          if (lru_kv_pkg::IDX_W'(i) == slot) begin
            recency_rank[i] <= '0;
          end else if (entry_valid[i]) begin
            recency_rank[i] <= recency_rank[i] + lru_kv_pkg::RANK_W'(1);
          end
        end
        entry_valid[slot] <= 1'b1;
        if (!do_evict) begin
          occupancy <= occupancy + lru_kv_pkg::OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter      <= '0;
      miss_counter     <= '0;
      eviction_counter <= '0;
    end else if (cmd.exec) begin
      if (!is_put && found && (hit_counter != '1)) begin
        hit_counter <= hit_counter + lru_kv_pkg::CNT_W'(1);
      end
      if (!is_put && !found && (miss_counter != '1)) begin
        miss_counter <= miss_counter + lru_kv_pkg::CNT_W'(1);
      end
      if (do_evict && (eviction_counter != '1)) begin
        eviction_counter <= eviction_counter + lru_kv_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit     <= found;
      evicted <= do_evict;
      if (!is_put && found) begin
        read_value <= lru_kv_pkg::FIELD_W'(entry_values[found_idx]);
      end else begin
        read_value <= '0;
      end
    end
  end

  // counters only move on execute, which waits for the result to drain
  assign hit_total      = hit_counter;
  assign miss_total     = miss_counter;
  assign eviction_total = eviction_counter;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupancy))
    else $error("occupancy out of step with valid entries");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && do_evict) |-> $onehot(lru_match))
    else $error("eviction without a unique least recent entry");

  a_insert_to_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && do_insert && !do_evict) |-> !entry_valid[slot])
    else $error("insert without eviction landed on a valid entry");

endmodule
`default_nettype wire

>>> bench/lru_cache_checker.sv
`timescale 1ns / 100ps
// Checker for the LRU key-value cache: predicts each result and compares it.
module lru_cache_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lru_kv_pkg::CAP_W-1:0]        cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                mode,
  input  logic [lru_kv_pkg::FIELD_W-1:0]      key,
  input  logic [lru_kv_pkg::FIELD_W-1:0]      value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                hit,
  input  logic [lru_kv_pkg::FIELD_W-1:0]      read_value,
  input  logic                                evicted,
  input  logic [lru_kv_pkg::CNT_W-1:0]        hit_total,
  input  logic [lru_kv_pkg::CNT_W-1:0]        miss_total,
  input  logic [lru_kv_pkg::CNT_W-1:0]        eviction_total,
  output int                                  failures,
  output int                                  pending_count
);

  typedef struct packed {
    logic                           was_hit;
    logic [lru_kv_pkg::FIELD_W-1:0] data;
    logic                           did_evict;
    logic [lru_kv_pkg::CNT_W-1:0]   hits;
    logic [lru_kv_pkg::CNT_W-1:0]   misses;
    logic [lru_kv_pkg::CNT_W-1:0]   evictions;
  } cache_result_t;

  // Shadow copy of the cache contents and counters
  logic [lru_kv_pkg::FIELD_W-1:0] slot_key  [lru_kv_pkg::ENTRIES];
  logic [lru_kv_pkg::FIELD_W-1:0] slot_val  [lru_kv_pkg::ENTRIES];
  logic                           slot_used [lru_kv_pkg::ENTRIES];
  int unsigned                    slot_age  [lru_kv_pkg::ENTRIES];
  int unsigned                    fill;
  logic [lru_kv_pkg::CNT_W-1:0]   hits_seen, misses_seen, evictions_seen;
  logic [lru_kv_pkg::CAP_W-1:0]   capacity;

  cache_result_t expected_results[$];
  int            result_number = 0;
  int            mismatch_count = 0;

  assign failures = mismatch_count;

  initial pending_count = 0;

  function automatic logic [lru_kv_pkg::CNT_W-1:0] bump(
      input logic [lru_kv_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int unsigned usable_entries();
    if (capacity == '0) return 1;
    if (capacity > lru_kv_pkg::ENTRIES) return lru_kv_pkg::ENTRIES;
    return capacity;
  endfunction

  // Entry becomes most recent; everything younger than it ages by one.
  task automatic promote(input int idx);
    int unsigned old_age;
    old_age = slot_age[idx];
    for (int i = 0; i < lru_kv_pkg::ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
    slot_age[idx] = 0;
  endtask

  task automatic cache_access(input logic op, input logic [lru_kv_pkg::FIELD_W-1:0] k,
                              input logic [lru_kv_pkg::FIELD_W-1:0] v,
                              output cache_result_t r);
    int          found;
    int          victim;
    int unsigned oldest;
    found  = -1;
    victim = -1;
    oldest = 0;
    r      = '0;
    for (int i = 0; i < lru_kv_pkg::ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    r.was_hit = (found >= 0);
    if (op == lru_kv_pkg::MODE_GET) begin
      if (found >= 0) begin
        r.data    = slot_val[found];
        hits_seen = bump(hits_seen);
        promote(found);
      end else begin
        misses_seen = bump(misses_seen);
      end
    end else if (found >= 0) begin
      slot_val[found] = v;
      promote(found);
    end else begin
      // new key: make room first if the cache is at (or above) capacity
      if (fill >= usable_entries()) begin
        for (int i = 0; i < lru_kv_pkg::ENTRIES; i++)
          if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        if (victim >= 0) begin
          slot_used[victim] = 1'b0;
          fill--;
          r.did_evict    = 1'b1;
          evictions_seen = bump(evictions_seen);
        end
      end
      if (victim < 0)
        for (int i = 0; i < lru_kv_pkg::ENTRIES; i++)
          if (victim < 0 && !slot_used[i]) victim = i;
      if (victim >= 0) begin
        for (int i = 0; i < lru_kv_pkg::ENTRIES; i++)
          if (slot_used[i]) slot_age[i]++;
        slot_key[victim]  = k;
        slot_val[victim]  = v;
        slot_used[victim] = 1'b1;
        slot_age[victim]  = 0;
        fill++;
      end
    end
    r.hits      = hits_seen;
    r.misses    = misses_seen;
    r.evictions = evictions_seen;
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [lru_kv_pkg::CNT_W-1:0] got,
                                 input logic [lru_kv_pkg::CNT_W-1:0] want);
    if (mismatch_count < 40)
      $display("%0t: result %0d: %s: got %h, expected %h", $realtime, result_number,
               what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (rst) begin
      capacity = lru_kv_pkg::CAP_RESET;
      for (int i = 0; i < lru_kv_pkg::ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill           = 0;
      hits_seen      = '0;
      misses_seen    = '0;
      evictions_seen = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_data;
      if (out_valid && out_ready) begin
        got.was_hit   = hit;
        got.data      = read_value;
        got.did_evict = evicted;
        got.hits      = hit_total;
        got.misses    = miss_total;
        got.evictions = eviction_total;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.was_hit !== want.was_hit) report_mismatch("hit", got.was_hit, want.was_hit);
          if (got.data !== want.data) report_mismatch("read_value", got.data, want.data);
          if (got.did_evict !== want.did_evict)
            report_mismatch("evicted", got.did_evict, want.did_evict);
          if (got.hits !== want.hits) report_mismatch("hit_total", got.hits, want.hits);
          if (got.misses !== want.misses)
            report_mismatch("miss_total", got.misses, want.misses);
          if (got.evictions !== want.evictions)
            report_mismatch("eviction_total", got.evictions, want.evictions);
        end
        result_number++;
      end
      if (in_valid && in_ready) begin
        cache_access(mode, key, value, want);
        expected_results = {expected_results, want};
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

>>> bench/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// Testbench top for the LRU key-value cache: stimulus, flow control and verdict.
module tb_lru_key_value_cache;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 78;
  localparam int LONG_HOLD   = 60;
  localparam int POOL_MAX    = 20;

  logic                                  clk       = 1'b0;
  logic                                  rst       = 1'b1;
  logic                                  cfg_we    = 1'b0;
  logic [lru_kv_pkg::CAP_W-1:0]          cfg_data  = '0;
  logic                                  in_valid  = 1'b0;
  logic                                  in_ready;
  logic                                  mode      = lru_kv_pkg::MODE_GET;
  logic signed [lru_kv_pkg::FIELD_W-1:0] key       = '0;
  logic signed [lru_kv_pkg::FIELD_W-1:0] value     = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  hit;
  logic signed [lru_kv_pkg::FIELD_W-1:0] read_value;
  logic                                  evicted;
  logic [lru_kv_pkg::CNT_W-1:0]          hit_total, miss_total, eviction_total;

  int failures;
  int pending_count;
  int tx_idle_pct  = 16;
  int rx_idle_pct  = 61;
  int stall_orders = 0;
  int stall_served = 0;
  int hold_left    = 0;

  // capacity per random phase: drops below occupancy, zero, above the entry count
  logic [lru_kv_pkg::CAP_W-1:0] phase_capacity [PHASES] =
    '{5'd4, 5'd0, 5'd16, 5'd1, 5'd31, 5'd2, 5'd17, 5'd9};

  always #5 clk = ~clk;

  lru_key_value_cache DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .key            (key),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .read_value     (read_value),
    .evicted        (evicted),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  lru_cache_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .key            (key),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .read_value     (read_value),
    .evicted        (evicted),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total),
    .failures       (failures),
    .pending_count  (pending_count)
  );

  // Result side: random back-pressure, plus a long hold-off when one is ordered.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_served != stall_orders) begin
      out_ready    <= 1'b0;
      hold_left    <= LONG_HOLD;
      stall_served <= stall_orders;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Returns at the edge where the request is taken; valid is left high so a
  // following request can go out back to back.
  task automatic send_request(input logic op, input logic [lru_kv_pkg::FIELD_W-1:0] k,
                              input logic [lru_kv_pkg::FIELD_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lru_kv_pkg::CAP_W-1:0] cap);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [lru_kv_pkg::FIELD_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [lru_kv_pkg::FIELD_W-1:0] key_pool [POOL_MAX];
    int                             pool_size;
    logic [lru_kv_pkg::FIELD_W-1:0] k;
    logic                           op;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty miss, key and value extremes, update, fill to 16, evict
    send_request(lru_kv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lru_kv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lru_kv_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lru_kv_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(lru_kv_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lru_kv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(lru_kv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lru_kv_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_1234);
    send_request(lru_kv_pkg::MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lru_kv_pkg::MODE_GET, 32'h0001_2345, 32'h0000_0000);
    for (int i = 1; i <= 12; i++) send_request(lru_kv_pkg::MODE_PUT, i, 32'hA000_0000 + i);
    send_request(lru_kv_pkg::MODE_PUT, 32'h0000_0100, 32'h5555_AAAA);
    send_request(lru_kv_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lru_kv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_capacity(phase_capacity[p]);
      if (p < 3) begin
        tx_idle_pct = 16;
        rx_idle_pct <= 61;
      end else if (p < 6) begin
        tx_idle_pct = 61;
        rx_idle_pct <= 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // long receiver hold-off while the sender keeps pushing
      if (p == 6) stall_orders <= stall_orders + 1;

      pool_size = $urandom_range(POOL_MAX, 2);
      for (int j = 0; j < pool_size; j++) key_pool[j] = $urandom();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(9) < 8) k = key_pool[$urandom_range(pool_size - 1)];
        else k = random_word();
        op = $urandom_range(1) ? lru_kv_pkg::MODE_PUT : lru_kv_pkg::MODE_GET;
        send_request(op, k, random_word());
      end
    end

    wait_drained();
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
